// ----- rtl/sust_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted unique set table package
// Shared widths, sizing constants, request codes and the cell control word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sust_pkg;

  // Number of cells in the table.
  localparam int unsigned CAPACITY = 64;

  // Key width and the width of the count field on the output.
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ENTRY_COUNT_W = 7;

  // Count register holds 0 .. CAPACITY.
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  // Request codes.
  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_type_e;

  // Shift commands broadcast to every cell.
  typedef struct packed {
    logic ins_en;
    logic rem_en;
  } cell_ctrl_t;

endpackage

// ----- rtl/sust_cell.sv -----
// ----------------------------------------------------------------------------
// Sorted unique set table cell
// Holds one key, compares it with the broadcast key and shifts it up or down.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sust_cell
  import sust_pkg::*;
(
  input  logic              clk_i,
  input  cell_ctrl_t        ctrl_i,
  input  logic [DATA_W-1:0] value_i,
  input  logic              occupied_i,
  input  logic [DATA_W-1:0] key_lo_i,
  input  logic              lt_lo_i,
  input  logic [DATA_W-1:0] key_hi_i,
  output logic [DATA_W-1:0] key_o,
  output logic              lt_o,
  output logic              eq_o
);

  logic [DATA_W-1:0] key_q;
  logic [DATA_W-1:0] key_d;

  // Local compare against the broadcast key, in signed order.
  assign lt_o  = occupied_i && ($signed(key_q) < $signed(value_i));
  assign eq_o  = occupied_i && (key_q == value_i);
  assign key_o = key_q;

  // Cells at or above the sorted slot move; cells below it hold.
  always_comb begin
    key_d = key_q;
    if (!lt_o) begin
      if (ctrl_i.ins_en) begin
        key_d = lt_lo_i ? value_i : key_lo_i;
      end else if (ctrl_i.rem_en) begin
        key_d = key_hi_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

// ----- rtl/sorted_unique_set_table.sv -----
// ----------------------------------------------------------------------------
// Sorted unique set table
// Ascending set of signed keys kept in a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Result: the result word is registered and appears in the cycle after the request word is taken.
// Throughput: one request per cycle; every cell compares in parallel and the
// whole chain shifts in the same cycle, so only the output register can stall.
// Reset: the entry count clears at once; cell contents stay undefined and are
// never read above the count.
`timescale 1ns / 1ps

module sorted_unique_set_table
  import sust_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               req_type_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     was_present_o,
  output logic                     changed_o,
  output logic                     full_drop_o,
  output logic [ENTRY_COUNT_W-1:0] entry_count_o
);

  logic [CNT_W-1:0]  count_q, count_d;
  logic              out_valid_q;
  logic              was_present_q, changed_q, full_drop_q;
  logic [ENTRY_COUNT_W-1:0] entry_count_q;

  logic [DATA_W-1:0] keys [CAPACITY];
  logic [CAPACITY-1:0] lt;
  logic [CAPACITY-1:0] eq;
  logic              in_acc;
  logic              present;
  logic              full;
  req_type_e         req;
  cell_ctrl_t        ctrl;
  logic              changed;
  logic              drop;

  // Handshake: take a word whenever the output register is free or draining.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign req        = req_type_e'(req_type_i);

  assign present = |eq;
  assign full    = (count_q == CNT_W'(CAPACITY));

  // Decide what the chain does with this request.
  always_comb begin
    ctrl.ins_en = 1'b0;
    ctrl.rem_en = 1'b0;
    changed     = 1'b0;
    drop        = 1'b0;
    count_d     = count_q;
    unique case (req)
      REQ_INSERT: begin
        if (!present) begin
          if (full) begin
            drop = 1'b1;
          end else begin
            ctrl.ins_en = in_acc;
            changed     = 1'b1;
            count_d     = count_q + 1'b1;
          end
        end
      end
      REQ_REMOVE: begin
        if (present) begin
          ctrl.rem_en = in_acc;
          changed     = 1'b1;
          count_d     = count_q - 1'b1;
        end
      end
      REQ_LOOKUP: begin
      end
      REQ_CLEAR: begin
        changed = 1'b1;
        count_d = '0;
      end
      default: begin
      end
    endcase
  end

  // The cell chain; each cell sees its lower and upper neighbor.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] key_lo;
    logic              lt_lo;
    logic [DATA_W-1:0] key_hi;
    logic              occupied;

    assign occupied = (CNT_W'(i) < count_q);

    if (i == 0) begin : g_first
      assign key_lo = value_i;
      assign lt_lo  = 1'b1;
    end else begin : g_mid_lo
      assign key_lo = keys[i-1];
      assign lt_lo  = lt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign key_hi = '0;
    end else begin : g_mid_hi
      assign key_hi = keys[i+1];
    end

    sust_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .value_i    (value_i),
      .occupied_i (occupied),
      .key_lo_i   (key_lo),
      .lt_lo_i    (lt_lo),
      .key_hi_i   (key_hi),
      .key_o      (keys[i]),
      .lt_o       (lt[i]),
      .eq_o       (eq[i])
    );
  end

  // Count and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result word register.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      was_present_q <= present;
      changed_q     <= changed;
      full_drop_q   <= drop;
      entry_count_q <= ENTRY_COUNT_W'(count_d);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign was_present_o = was_present_q;
  assign changed_o     = changed_q;
  assign full_drop_o   = full_drop_q;
  assign entry_count_o = entry_count_q;

  // Checks on the table logic.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_drop_no_change : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(full_drop_o && changed_o))
    else $error("dropped insert reported as a change");

  a_lookup_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (req == REQ_LOOKUP) |=> !changed_q && (count_q == $past(count_q)))
    else $error("lookup changed the table");

  a_insert_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ins_en |=> count_q == CNT_W'($past(count_q) + 1'b1))
    else $error("insert did not grow the count by one");

endmodule
